[hw/rtl/lfb_pkg.sv]
// ----------------------------------------------------------------------------
// lfb_pkg: shared types and constants of the frame buffer refresh block
// Transaction payloads, the storage control struct, operation codes, the
// sequencer states and the display command bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package lfb_pkg;

   localparam int FOLDED_ROWS   = 32;
   localparam int WORDS_PER_ROW = 16;
   localparam int ROW_W         = $clog2(FOLDED_ROWS);
   localparam int WORD_W        = $clog2(WORDS_PER_ROW);
   localparam int ADDR_W        = ROW_W + WORD_W;
   localparam int STORE_DEPTH   = FOLDED_ROWS * WORDS_PER_ROW;
   localparam int PIX_W         = 16;

   localparam logic [1:0] OP_SET_PIXEL = 2'd0;
   localparam logic [1:0] OP_CLEAR     = 2'd1;
   localparam logic [1:0] OP_PAINT     = 2'd2;

   localparam logic [7:0] MODE_EXT  = 8'h34;
   localparam logic [7:0] MODE_GFX  = 8'h36;
   localparam logic [7:0] ADDR_BASE = 8'h80;

   localparam logic [1:0] HDR_MODE_EXT = 2'd0;
   localparam logic [1:0] HDR_MODE_GFX = 2'd1;
   localparam logic [1:0] HDR_ROW     = 2'd2;
   localparam logic [1:0] HDR_COLUMN  = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic [4:0] paint_row;
   } req_type;

   typedef struct packed {
      logic [7:0] lcd_byte;
      logic       is_data;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  wr_data;
   } mem_req_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_READ,
      ST_PIX_WRITE,
      ST_PAINT_HDR,
      ST_PAINT_HI,
      ST_PAINT_LO
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/lfb_store.sv]
// ----------------------------------------------------------------------------
// lfb_store: folded frame buffer storage
// Single-port word store with one write and/or one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfb_store (
   input  wire logic                      clock,
   input  wire lfb_pkg::mem_req_type      mem_req,
   output logic [lfb_pkg::PIX_W-1:0]      rd_data
);

   logic [lfb_pkg::PIX_W-1:0] frame_words_ff [lfb_pkg::STORE_DEPTH];
   logic [lfb_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         frame_words_ff[mem_req.addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= frame_words_ff[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/lcd_framebuffer_refresh.sv]
// ----------------------------------------------------------------------------
// lcd_framebuffer_refresh: 128x64 monochrome frame buffer and row painter
// Set pixel reads the store word, then writes it back with its bit set; clear
// writes zero to all 512 words. Paint registers its first byte from the header
// state, then gives one byte per cycle without stalls: 36 bytes for row 0, 34 for
// other rows. Reset starts a clearing pass; no transaction is accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_framebuffer_refresh (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lfb_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lfb_pkg::rsp_type      rsp_payload
);

   lfb_pkg::state_type   state_ff, state_in;
   logic [lfb_pkg::ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [1:0]           hdr_idx_ff, hdr_idx_in;
   logic [lfb_pkg::WORD_W-1:0] word_ff, word_in;
   logic [lfb_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [lfb_pkg::ADDR_W-1:0] pix_addr_ff, pix_addr_in;
   logic [3:0]           pix_bit_ff, pix_bit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lfb_pkg::rsp_type     rsp_ff, rsp_in;

   lfb_pkg::mem_req_type mem_req;
   logic [lfb_pkg::PIX_W-1:0] rd_data;
   logic [lfb_pkg::PIX_W-1:0] pix_mask;
   logic                 req_accept;
   logic                 out_free;
   logic                 on_screen;
   logic [7:0]           hdr_byte;

   lfb_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != lfb_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign on_screen  = !req_payload.pixel_x[7] && (req_payload.pixel_y[7:6] == 2'b00);
   assign pix_mask   = {1'b1, {(lfb_pkg::PIX_W-1){1'b0}}} >> pix_bit_ff;

   always_comb begin
      unique case (hdr_idx_ff)
         lfb_pkg::HDR_MODE_EXT: hdr_byte = lfb_pkg::MODE_EXT;
         lfb_pkg::HDR_MODE_GFX: hdr_byte = lfb_pkg::MODE_GFX;
         lfb_pkg::HDR_ROW:      hdr_byte = lfb_pkg::ADDR_BASE + {3'b000, row_ff};
         lfb_pkg::HDR_COLUMN:   hdr_byte = lfb_pkg::ADDR_BASE;
         default:               hdr_byte = lfb_pkg::ADDR_BASE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      hdr_idx_in   = hdr_idx_ff;
      word_in      = word_ff;
      row_in       = row_ff;
      pix_addr_in  = pix_addr_ff;
      pix_bit_in   = pix_bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_req      = '0;

      unique case (state_ff)
         lfb_pkg::ST_CLEAR: begin
            mem_req.wr_en = 1'b1;
            mem_req.addr  = clr_addr_ff;
            clr_addr_in   = clr_addr_ff + 1'b1;
            if (clr_addr_ff == {lfb_pkg::ADDR_W{1'b1}}) begin
               state_in = lfb_pkg::ST_IDLE;
            end
         end
         lfb_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_payload.op)
                  lfb_pkg::OP_SET_PIXEL: begin
                     pix_addr_in = {req_payload.pixel_y[4:0], req_payload.pixel_y[5],
                                    req_payload.pixel_x[6:4]};
                     pix_bit_in  = req_payload.pixel_x[3:0];
                     if (on_screen) begin
                        state_in = lfb_pkg::ST_PIX_READ;
                     end
                  end
                  lfb_pkg::OP_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = lfb_pkg::ST_CLEAR;
                  end
                  lfb_pkg::OP_PAINT: begin
                     row_in     = req_payload.paint_row;
                     hdr_idx_in = (req_payload.paint_row == '0) ? lfb_pkg::HDR_MODE_EXT
                                                                : lfb_pkg::HDR_ROW;
                     state_in   = lfb_pkg::ST_PAINT_HDR;
                  end
                  default: begin
                     state_in = lfb_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         lfb_pkg::ST_PIX_READ: begin
            mem_req.rd_en = 1'b1;
            mem_req.addr  = pix_addr_ff;
            state_in      = lfb_pkg::ST_PIX_WRITE;
         end
         lfb_pkg::ST_PIX_WRITE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.addr    = pix_addr_ff;
            mem_req.wr_data = rd_data | pix_mask;
            state_in        = lfb_pkg::ST_IDLE;
         end
         lfb_pkg::ST_PAINT_HDR: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.lcd_byte = hdr_byte;
               rsp_in.is_data  = 1'b0;
               rsp_in.last     = 1'b0;
               hdr_idx_in      = hdr_idx_ff + 1'b1;
               if (hdr_idx_ff == lfb_pkg::HDR_COLUMN) begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = {row_ff, {lfb_pkg::WORD_W{1'b0}}};
                  word_in       = '0;
                  state_in      = lfb_pkg::ST_PAINT_HI;
               end
            end
         end
         lfb_pkg::ST_PAINT_HI: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.lcd_byte = rd_data[15:8];
               rsp_in.is_data  = 1'b1;
               rsp_in.last     = 1'b0;
               state_in        = lfb_pkg::ST_PAINT_LO;
            end
         end
         lfb_pkg::ST_PAINT_LO: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.lcd_byte = rd_data[7:0];
               rsp_in.is_data  = 1'b1;
               rsp_in.last     = (word_ff == {lfb_pkg::WORD_W{1'b1}});
               if (word_ff == {lfb_pkg::WORD_W{1'b1}}) begin
                  state_in = lfb_pkg::ST_IDLE;
               end else begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = {row_ff, word_ff + 1'b1};
                  word_in       = word_ff + 1'b1;
                  state_in      = lfb_pkg::ST_PAINT_HI;
               end
            end
         end
         default: begin
            state_in = lfb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfb_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_idx_ff  <= hdr_idx_in;
      word_ff     <= word_in;
      row_ff      <= row_in;
      pix_addr_ff <= pix_addr_in;
      pix_bit_ff  <= pix_bit_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The single store port never sees a read and a write in the same cycle.
   a_mem_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en))
      else $error("store read and write in the same cycle");

   // The read-modify-write of a pixel always follows its read cycle.
   a_pix_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lfb_pkg::ST_PIX_WRITE) |-> ($past(state_ff) == lfb_pkg::ST_PIX_READ))
      else $error("pixel write without a preceding read");

   // A final byte is always a display data byte.
   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |-> rsp_ff.is_data)
      else $error("last mark on a command byte");

   // Painting a row other than zero skips the mode bytes.
   a_skip_mode: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_payload.op == lfb_pkg::OP_PAINT) && (req_payload.paint_row != '0))
      |=> (hdr_idx_ff == lfb_pkg::HDR_ROW))
      else $error("mode bytes not skipped for a nonzero row");

endmodule

`default_nettype wire
